[src/rspr_pkg.sv]
// rspr_pkg: shared types and constants for the RLE sprite palette remap block.
// Depends on nothing; imported by every module under src.
`timescale 1ns / 1ps

package rspr_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned PAL_DEPTH = 256;
   localparam int unsigned PAL_AW   = $clog2(PAL_DEPTH);

   // Longest literal run; anything longer is a fill run with one pixel.
   localparam logic [BYTE_W-1:0] FILL_THRESHOLD = 8'd65;

   // Request kind carried on req_tuser
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_DATA = 1'b1
   } rspr_op_type;

   // Parser state
   typedef enum logic {
      PARSE_CONTROL = 1'b0,
      PARSE_PIXELS  = 1'b1
   } rspr_mode_type;

   // Per-byte decode from the parser to the pipeline
   typedef struct packed {
      logic is_pixel;
      logic run_error;
   } rspr_parse_type;

endpackage

[src/rspr_palette_ram.sv]
// rspr_palette_ram: 256 x 8 palette translation memory, one write and one
// registered read port. Depends on rspr_pkg.
`timescale 1ns / 1ps

module rspr_palette_ram
   import rspr_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [PAL_AW-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [PAL_AW-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [PAL_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered; holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rspr_parser.sv]
// rspr_parser: run-length control parser; tracks the pixel bytes still due
// and classifies each frame byte. Depends on rspr_pkg.
`timescale 1ns / 1ps

module rspr_parser
   import rspr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              end_of_frame,
   output rspr_parse_type    parse
);

   rspr_mode_type      mode_ff, mode_in, mode_next;
   logic [COUNT_W-1:0] left_ff, left_in, left_next;
   logic [COUNT_W-1:0] left_dec;
   logic [BYTE_W-1:0]  mag;

   // Magnitude of a negative control byte, 1..128
   assign mag      = BYTE_W'(~data_byte + BYTE_W'(1));
   assign left_dec = (left_ff != '0) ? COUNT_W'(left_ff - COUNT_W'(1)) : '0;

   // Next state from the current byte, before end of frame
   always_comb begin
      mode_next = mode_ff;
      left_next = left_ff;
      unique case (mode_ff)
         PARSE_PIXELS: begin
            left_next = left_dec;
            mode_next = (left_dec == '0) ? PARSE_CONTROL : PARSE_PIXELS;
         end
         PARSE_CONTROL: begin
            if (data_byte[BYTE_W-1]) begin
               left_next = (mag > FILL_THRESHOLD) ? COUNT_W'(1) : mag[COUNT_W-1:0];
               mode_next = PARSE_PIXELS;
            end
         end
         default: begin
            mode_next = PARSE_CONTROL;
            left_next = '0;
         end
      endcase
   end

   // Register update; end of frame returns to the reset state
   always_comb begin
      mode_in = mode_ff;
      left_in = left_ff;
      if (advance) begin
         if (end_of_frame) begin
            mode_in = PARSE_CONTROL;
            left_in = '0;
         end else begin
            mode_in = mode_next;
            left_in = left_next;
         end
      end
   end

   // Outputs for the current byte
   always_comb begin
      parse.is_pixel  = (mode_ff == PARSE_PIXELS);
      parse.run_error = end_of_frame && (mode_next == PARSE_PIXELS) && (left_next != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= PARSE_CONTROL;
         left_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         left_ff <= left_in;
      end
   end

`ifndef SYNTHESIS
   a_control_no_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == PARSE_CONTROL) |-> (left_ff == '0))
      else $error("parser idle with pixels still counted");

   a_pixels_have_count: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == PARSE_PIXELS) |-> (left_ff != '0))
      else $error("parser expects pixels with empty count");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && end_of_frame) |=> (mode_ff == PARSE_CONTROL && left_ff == '0))
      else $error("parser not cleared after end of frame");
`endif

endmodule

[src/rle_sprite_palette_remap_top.sv]
// Pipeline: an accepted frame byte passes stage 1 (palette read) and the stage 2 output
// register before rsp. Throughput: one transaction per cycle unless rsp stalls, loads
// and frame bytes alike; the palette memory takes one write or one read each cycle.
// Reset (synchronous, active high) clears the parser and both pipeline
// valids; palette contents are kept and are undefined until loaded.
// Depends on rspr_pkg, rspr_palette_ram and rspr_parser.
`timescale 1ns / 1ps

module rle_sprite_palette_remap_top
   import rspr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // table_index[7:0], table_value[15:8], data_byte[23:16]
   input  logic        req_tuser,   // operation[0]
   input  logic        req_tlast,   // end_of_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], run_error[8], zero[15:9]
   output logic        rsp_tuser,   // is_pixel[0]
   output logic        rsp_tlast    // frame_done
);

   logic              req_accept, data_accept, load_accept;
   logic              s2_ready;
   logic [BYTE_W-1:0] ram_rd_data;
   rspr_parse_type    parse;

   // Stage 1: memory read in flight
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   rspr_parse_type    s1_parse_ff;
   logic              s1_eof_ff;

   // Stage 2: output register
   logic              s2_valid_ff, s2_valid_in;
   logic [BYTE_W-1:0] s2_byte_ff, s2_byte_in;
   logic              s2_pixel_ff, s2_error_ff, s2_eof_ff;

   // Handshake and request decode
   assign s2_ready    = !s2_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || s2_ready;
   assign req_accept  = req_tvalid && req_tready;
   assign data_accept = req_accept && (rspr_op_type'(req_tuser) == OP_DATA);
   assign load_accept = req_accept && (rspr_op_type'(req_tuser) == OP_LOAD);

   rspr_palette_ram u_ram (
      .clock   (clock),
      .wr_en   (load_accept),
      .wr_addr (req_tdata[7:0]),
      .wr_data (req_tdata[15:8]),
      .rd_en   (data_accept),
      .rd_addr (req_tdata[23:16]),
      .rd_data (ram_rd_data)
   );

   rspr_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .advance      (data_accept),
      .data_byte    (req_tdata[23:16]),
      .end_of_frame (req_tlast),
      .parse        (parse)
   );

   // Advance stage 1 when it drains; only frame bytes produce a result
   assign s1_valid_in = req_tready ? data_accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (data_accept) begin
         s1_byte_ff  <= req_tdata[23:16];
         s1_parse_ff <= parse;
         s1_eof_ff   <= req_tlast;
      end
   end

   // Select translated pixel or raw control byte into the output register
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s2_byte_in  = s1_parse_ff.is_pixel ? ram_rd_data : s1_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_byte_ff  <= s2_byte_in;
         s2_pixel_ff <= s1_parse_ff.is_pixel;
         s2_error_ff <= s1_parse_ff.run_error;
         s2_eof_ff   <= s1_eof_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {7'd0, s2_error_ff, s2_byte_ff};
   assign rsp_tuser  = s2_pixel_ff;
   assign rsp_tlast  = s2_eof_ff;

`ifndef SYNTHESIS
   a_error_only_at_eof: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_error_ff) |-> s2_eof_ff)
      else $error("run error flagged away from end of frame");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while both stages are stalled");

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_byte_ff)
                                      && $stable(ram_rd_data)))
      else $error("stage 1 changed while stalled");
`endif

endmodule
